>>> sv/rtxtrk_pkg.sv
// Package: shared constants, types and codes for the retransmit range tracker.
package rtxtrk_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 16;
    localparam int ACK_W       = 20;
    localparam int COUNT_OUT_W = 5;
    localparam int SUM_W       = SEQ_W + 1;

    localparam logic [ACK_W-1:0] ACK_MAX = '1;

    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_LOOKUP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq_number;
        logic [LEN_W-1:0] data_len;
        logic [SEQ_W-1:0] ack_number;
        logic [SEQ_W-1:0] query_seq;
    } in_t;

    typedef struct packed {
        logic [ACK_W-1:0]       acked_bytes;
        logic                   found;
        logic [SEQ_W-1:0]       found_begin;
        logic [SEQ_W-1:0]       found_end;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] entry_count;
    } out_t;

    typedef struct packed {
        logic [SEQ_W-1:0] rbeg;
        logic [SEQ_W-1:0] rend;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> sv/rtxtrk_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module rtxtrk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tcp_retransmit_range_tracker_unit.sv
// Top level: ordered table of unacknowledged TCP sequence ranges.
//
//  channel | ports                      | payload          | role
//  --------+----------------------------+------------------+--------------------------
//  input   | s_valid, s_ready, s_data   | rtxtrk_pkg::in_t | send/ack/lookup/clear
//  result  | m_valid, m_ready, m_data   | rtxtrk_pkg::out_t| one result per request
//
// Acks and lookups walk the table RAM one entry per cycle through its single
// registered read port and one shared subtract/compare unit; a lookup stops at
// the first entry that covers the query.
// Reset (aresetn low, synchronous) empties the table; the RAM itself is not
// cleared, entries at or above the count are never used.
// A stalled result sits in the output register; the next request is taken
// meanwhile, and its result waits until the output register frees up.
module tcp_retransmit_range_tracker_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rtxtrk_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rtxtrk_pkg::out_t m_data
);

    rtxtrk_pkg::state_t state_reg, state_next;
    rtxtrk_pkg::in_t    req_reg, req_next;
    rtxtrk_pkg::out_t   res_reg, res_next;
    rtxtrk_pkg::out_t   m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    logic [rtxtrk_pkg::CNT_W-1:0] occ_reg, occ_next;
    logic [rtxtrk_pkg::CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [rtxtrk_pkg::CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic                         pend_reg, pend_next;
    logic [rtxtrk_pkg::ACK_W-1:0] acc_reg, acc_next;

    // table RAM ports
    logic                          ram_we;
    logic [rtxtrk_pkg::IDX_W-1:0]  ram_waddr;
    rtxtrk_pkg::entry_t            ram_wdata;
    logic [rtxtrk_pkg::IDX_W-1:0]  ram_raddr;
    logic [rtxtrk_pkg::ENTRY_W-1:0] ram_rdata;
    rtxtrk_pkg::entry_t            cur;

    // shared entry unit
    logic                         retire;
    logic                         trim;
    logic [rtxtrk_pkg::SEQ_W-1:0] sub_hi;
    logic [rtxtrk_pkg::SEQ_W-1:0] delta;
    logic [rtxtrk_pkg::SUM_W-1:0] sum;
    logic [rtxtrk_pkg::ACK_W-1:0] acc_sat;
    logic                         hit;
    logic                         more;

    logic [rtxtrk_pkg::CNT_W+rtxtrk_pkg::COUNT_OUT_W-1:0] occ_ext;

    rtxtrk_ram #(
        .WIDTH (rtxtrk_pkg::ENTRY_W),
        .DEPTH (rtxtrk_pkg::QUEUE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur       = rtxtrk_pkg::entry_t'(ram_rdata);
    assign ram_raddr = rd_idx_reg[rtxtrk_pkg::IDX_W-1:0];
    assign more      = (rd_idx_reg < occ_reg);

    // Classify the entry just read: retire it, trim its front, or keep it whole.
    // One subtractor serves both the retired length and the trimmed part.
    always_comb begin
        retire = (cur.rend <= req_reg.ack_number);
        trim   = !retire && (req_reg.ack_number > cur.rbeg);
        sub_hi = retire ? cur.rend : req_reg.ack_number;
        delta  = (retire || trim) ? (sub_hi - cur.rbeg) : '0;
        sum    = rtxtrk_pkg::SUM_W'(acc_reg) + rtxtrk_pkg::SUM_W'(delta);
        if (sum > rtxtrk_pkg::SUM_W'(rtxtrk_pkg::ACK_MAX)) begin
            acc_sat = rtxtrk_pkg::ACK_MAX;
        end else begin
            acc_sat = sum[rtxtrk_pkg::ACK_W-1:0];
        end
        hit = (req_reg.query_seq >= cur.rbeg) && (req_reg.query_seq < cur.rend);
    end

    assign occ_ext = (rtxtrk_pkg::CNT_W + rtxtrk_pkg::COUNT_OUT_W)'(occ_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rtxtrk_pkg::ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        acc_reg    <= acc_next;
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        occ_next     = occ_reg;
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        pend_next    = 1'b0;
        acc_next     = acc_reg;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = wr_idx_reg[rtxtrk_pkg::IDX_W-1:0];
        ram_wdata    = cur;

        // drop the held result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            rtxtrk_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next    = s_data;
                    res_next    = '0;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    acc_next    = '0;
                    state_next  = rtxtrk_pkg::ST_RESP;
                    case (rtxtrk_pkg::kind_t'(s_data.kind))
                        rtxtrk_pkg::KIND_SEND: begin
                            // append a nonempty range at the tail, or flag a full table
                            if (s_data.data_len != '0) begin
                                if (occ_reg >= rtxtrk_pkg::CNT_W'(rtxtrk_pkg::QUEUE_DEPTH)) begin
                                    res_next.dropped = 1'b1;
                                end else begin
                                    ram_we         = 1'b1;
                                    ram_waddr      = occ_reg[rtxtrk_pkg::IDX_W-1:0];
                                    ram_wdata.rbeg = s_data.seq_number;
                                    ram_wdata.rend = s_data.seq_number
                                        + rtxtrk_pkg::SEQ_W'(s_data.data_len);
                                    occ_next       = occ_reg + rtxtrk_pkg::CNT_W'(1);
                                end
                            end
                        end
                        rtxtrk_pkg::KIND_ACK: begin
                            state_next = rtxtrk_pkg::ST_ACK;
                        end
                        rtxtrk_pkg::KIND_LOOKUP: begin
                            state_next = rtxtrk_pkg::ST_LOOKUP;
                        end
                        rtxtrk_pkg::KIND_CLEAR: begin
                            occ_next = '0;
                        end
                        default: begin
                            state_next = rtxtrk_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            rtxtrk_pkg::ST_ACK: begin
                // issue the next read while the previous entry is handled
                if (more) begin
                    rd_idx_next = rd_idx_reg + rtxtrk_pkg::CNT_W'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    acc_next = acc_sat;
                    if (!retire) begin
                        // compact: write the kept entry at the write index
                        ram_we         = 1'b1;
                        ram_wdata.rbeg = trim ? req_reg.ack_number : cur.rbeg;
                        ram_wdata.rend = cur.rend;
                        wr_idx_next    = wr_idx_reg + rtxtrk_pkg::CNT_W'(1);
                    end
                end
                if (!more && !pend_reg) begin
                    occ_next             = wr_idx_reg;
                    res_next.acked_bytes = acc_reg;
                    state_next           = rtxtrk_pkg::ST_RESP;
                end
            end

            rtxtrk_pkg::ST_LOOKUP: begin
                if (pend_reg && hit) begin
                    // oldest covering entry wins; stop the walk
                    res_next.found       = 1'b1;
                    res_next.found_begin = cur.rbeg;
                    res_next.found_end   = cur.rend;
                    state_next           = rtxtrk_pkg::ST_RESP;
                end else if (more) begin
                    rd_idx_next = rd_idx_reg + rtxtrk_pkg::CNT_W'(1);
                    pend_next   = 1'b1;
                end else if (!pend_reg) begin
                    state_next = rtxtrk_pkg::ST_RESP;
                end
            end

            rtxtrk_pkg::ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next             = res_reg;
                    m_data_next.entry_count = occ_ext[rtxtrk_pkg::COUNT_OUT_W-1:0];
                    m_valid_next            = 1'b1;
                    state_next              = rtxtrk_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rtxtrk_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
